// ===== sv/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, constants and the key ordering for the priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 7;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int EXT_W    = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic MODE_MAX = 1'b0;

  typedef logic signed [KEY_W-1:0] key_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic do_insert;
    logic do_pop;
    logic mode;
    key_t new_key;
  } bhpq_op_t;

  // true when a must sit nearer the top than b
  function automatic logic ranks_above(input logic mode, input key_t a, input key_t b);
    ranks_above = (mode == MODE_MAX) ? (a > b) : (a < b);
  endfunction

endpackage

// ===== sv/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Bounded priority queue of signed keys, kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// the result word is registered and appears in the cycle after the request is accepted
// throughput: one insert or pop per cycle while the result side does not stall
// the result register lets a new request in while it is being taken
// reset clears the fill count, the order mode and the result valid;
// key slots are not cleared, slots at or above the fill count never reach the result
module binary_heap_priority_queue import bhpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  key_t              in_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output key_t              out_popped_key,
  output logic [OCC_W-1:0]  out_occupancy
);

  logic              mode_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;
  key_t              popped_r;
  key_t              popped_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic [EXT_W-1:0]  occ_ext;

  logic     accept;
  logic     full;
  logic     empty;
  bhpq_op_t op;

  key_t cell_key  [CAPACITY];
  logic cell_keep [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  assign op.do_insert = accept && (in_req_type == REQ_INSERT) && !full;
  assign op.do_pop    = accept && (in_req_type == REQ_POP) && !empty;
  assign op.mode      = mode_r;
  assign op.new_key   = in_key;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic prev_keep;
      key_t prev_key;
      key_t next_key;
      logic occ;

      assign occ = (CNT_W'(i) < count_r);

      if (i == 0) begin : g_head
        assign prev_keep = 1'b1;
        assign prev_key  = in_key;
      end else begin : g_body
        assign prev_keep = cell_keep[i-1];
        assign prev_key  = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign next_key = '0;
      end else begin : g_mid
        assign next_key = cell_key[i+1];
      end

      bhpq_cell u_cell (
        .clk       (clk),
        .op        (op),
        .occ       (occ),
        .prev_keep (prev_keep),
        .prev_key  (prev_key),
        .next_key  (next_key),
        .keep      (cell_keep[i]),
        .key       (cell_key[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    popped_nxt = '0;
    if (op.do_insert) begin
      count_nxt = count_r + 1'b1;
    end else if (op.do_pop) begin
      count_nxt  = count_r - 1'b1;
      popped_nxt = cell_key[0];
    end else if (in_req_type == REQ_POP) begin
      status_nxt = STAT_EMPTY;
    end else begin
      status_nxt = STAT_FULL;
    end
  end

  assign occ_ext = EXT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_MAX;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // mode only changes on an empty queue so the stored order stays valid
      if (cfg_we && empty) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      popped_r <= popped_nxt;
      occ_r    <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_popped_key = popped_r;
  assign out_occupancy  = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_pop_top: assert property (@(posedge clk) disable iff (!rst_n)
    op.do_pop |=> (out_status == STAT_OK) && (out_popped_key == $past(cell_key[0])))
    else $error("pop did not return the head key");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req_type == REQ_INSERT) && full |=> (out_status == STAT_FULL) && full)
    else $error("insert on full queue not dropped");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> !ranks_above(mode_r, cell_key[1], cell_key[0]))
    else $error("chain head out of order");

endmodule

// ===== sv/bhpq_cell.sv =====
// ----------------------------------------------------------------------------
// bhpq_cell
// One slot of the sorted chain: holds a key, shifts down on insert, up on pop.
// ----------------------------------------------------------------------------
module bhpq_cell import bhpq_pkg::*; (
  input  logic     clk,
  input  bhpq_op_t op,
  input  logic     occ,        // slot holds a live key
  input  logic     prev_keep,  // slot above stays in place on insert
  input  key_t     prev_key,
  input  key_t     next_key,
  output logic     keep,
  output key_t     key
);

  key_t key_r;
  key_t key_nxt;

  // sorted chain: keep is a prefix, the first slot that moves takes the new word
  assign keep = occ && !ranks_above(op.mode, op.new_key, key_r);
  assign key  = key_r;

  always_comb begin
    key_nxt = key_r;
    if (op.do_insert && !keep) begin
      key_nxt = prev_keep ? op.new_key : prev_key;
    end else if (op.do_pop) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== verif/binary_heap_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_tb
// Drives insert and pop words into the queue with random gaps and stalls,
// predicts every result with a software heap and checks each field.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam logic MODE_MIN    = 1'b1;
  localparam int   STALL_LIMIT = 2000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    key_t              popped;
    logic [OCC_W-1:0]  occ;
  } heap_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_req_type = REQ_INSERT;
  key_t              in_key = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  key_t              out_popped_key;
  logic [OCC_W-1:0]  out_occupancy;

  // software copy of the heap
  key_t         model_keys [CAPACITY];
  int           model_count = 0;
  logic         model_mode = MODE_MAX;
  heap_result_t pending_results [$];
  heap_result_t want;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           idle_max = 16;

  binary_heap_priority_queue dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_popped_key (out_popped_key),
    .out_occupancy  (out_occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic outranks(input key_t a, input key_t b);
    return (model_mode == MODE_MAX) ? (a > b) : (a < b);
  endfunction

  function automatic heap_result_t heap_apply(input logic req, input key_t k);
    heap_result_t r;
    int   i;
    int   p;
    int   l;
    int   best;
    logic settled;
    key_t t;
    r.status = STAT_OK;
    r.popped = '0;
    settled  = 1'b0;
    if (req == REQ_INSERT) begin
      if (model_count >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        i = model_count;
        model_keys[i] = k;
        model_count++;
        while (i > 0 && !settled) begin
          p = (i - 1) / 2;
          if (!outranks(model_keys[i], model_keys[p])) begin
            settled = 1'b1;
          end else begin
            t = model_keys[i];
            model_keys[i] = model_keys[p];
            model_keys[p] = t;
            i = p;
          end
        end
      end
    end else if (model_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.popped = model_keys[0];
      model_count--;
      model_keys[0] = model_keys[model_count];
      i = 0;
      while (!settled) begin
        l = 2 * i + 1;
        if (l >= model_count) begin
          settled = 1'b1;
        end else begin
          best = l;
          // ties keep the left child
          if (l + 1 < model_count && outranks(model_keys[l + 1], model_keys[l]))
            best = l + 1;
          if (!outranks(model_keys[best], model_keys[i])) begin
            settled = 1'b1;
          end else begin
            t = model_keys[i];
            model_keys[i] = model_keys[best];
            model_keys[best] = t;
            i = best;
          end
        end
      end
    end
    r.occ = OCC_W'(model_count);
    return r;
  endfunction

  function automatic int pick_gap();
    if (idle_max == 0 || $urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(1, idle_max);
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return key_t'(int'($urandom_range(0, 8)) - 4);
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // one word per call; valid is only lowered when a gap follows
  task automatic send_word(input logic req, input key_t k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key      <= k;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(heap_apply(req, k));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    // the queue ignores a mode change while it holds keys
    if (model_count == 0)
      model_mode = value;
    cfg_we <= 1'b0;
  endtask

  task automatic drain_queue();
    while (model_count > 0) send_word(REQ_POP, pick_key());
  endtask

  task automatic test_empty_pop();
    send_word(REQ_POP, pick_key());
  endtask

  task automatic test_key_extremes();
    send_word(REQ_INSERT, 32'sh7fffffff);
    send_word(REQ_INSERT, 32'sh80000000);
    send_word(REQ_INSERT, 32'sh00000000);
    send_word(REQ_INSERT, 32'shffffffff);
    send_word(REQ_INSERT, 32'sh00000000);
    repeat (6) send_word(REQ_POP, pick_key());
  endtask

  task automatic test_mode_lock();
    send_word(REQ_INSERT, 32'sd10);
    send_word(REQ_INSERT, 32'sd20);
    wait_results();
    cfg_write(MODE_MIN);
    send_word(REQ_POP, pick_key());
    send_word(REQ_POP, pick_key());
  endtask

  task automatic test_min_order();
    wait_results();
    cfg_write(MODE_MIN);
    send_word(REQ_INSERT, 32'sh80000000);
    send_word(REQ_INSERT, 32'sh7fffffff);
    send_word(REQ_INSERT, -32'sd5);
    repeat (3) send_word(REQ_POP, pick_key());
  endtask

  task automatic test_random_traffic(input int count, input int insert_pct, input logic mode);
    int n;
    drain_queue();
    wait_results();
    cfg_write(mode);
    for (n = 0; n < count; n++) begin
      idle_max = (n < count / 4) ? 0 : 16;
      if (n == count / 2)
        wait_results();
      send_word(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP, pick_key());
    end
    idle_max = 16;
  endtask

  task automatic test_fill_overflow(input logic mode);
    drain_queue();
    wait_results();
    cfg_write(mode);
    while (model_count < CAPACITY) send_word(REQ_INSERT, pick_key());
    repeat (4) send_word(REQ_INSERT, pick_key());
    drain_queue();
    send_word(REQ_POP, pick_key());
  endtask

  // result side holds out_stall for a random gap, possibly none, before each word
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("binary_heap_priority_queue test failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_popped_key !== want.popped)
            report_mismatch($sformatf("popped key %0d, expected %0d",
                                      out_popped_key, want.popped));
          if (out_occupancy !== want.occ)
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      out_occupancy, want.occ));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pop();
    test_key_extremes();
    test_mode_lock();
    test_min_order();
    test_random_traffic(100, 70, MODE_MAX);
    test_fill_overflow(MODE_MIN);
    test_random_traffic(100, 55, MODE_MIN);
    test_random_traffic(60, 50, MODE_MAX);
    wait_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("binary_heap_priority_queue test passed");
    else
      $display("binary_heap_priority_queue test failed");
    $finish;
  end

endmodule
